// ===== src/imai_pkg.sv =====
`default_nettype none

package imai_pkg;

   // Order limit and widths of the stored values.
   localparam int MAX_N     = 4;
   localparam int ELEM_W    = 8;
   localparam int ADJ_W     = 26;
   localparam int DET_W     = 34;
   localparam int IDX_W     = 2;
   localparam int ADDR_W    = 4;
   localparam int CNT_W     = 5;
   localparam int DIV_STEPS = 26;

   // Register map: word index of the order register.
   localparam logic REG_SIZE = 1'b0;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Column taken at minor row t by permutation p of an m by m minor.
   function automatic logic [1:0] perm_col(input logic [1:0] m, input logic [2:0] p,
                                           input logic [1:0] t);
      logic [5:0] cols;
      cols = 6'b00_00_00;
      case (m)
         2'd3: begin
            case (p)
               3'd0:    cols = 6'b10_01_00;
               3'd1:    cols = 6'b01_10_00;
               3'd2:    cols = 6'b10_00_01;
               3'd3:    cols = 6'b00_10_01;
               3'd4:    cols = 6'b01_00_10;
               3'd5:    cols = 6'b00_01_10;
               default: cols = 6'b10_01_00;
            endcase
         end
         2'd2:    cols = p[0] ? 6'b00_00_01 : 6'b00_01_00;
         default: cols = 6'b00_00_00;
      endcase
      case (t)
         2'd0:    return cols[1:0];
         2'd1:    return cols[3:2];
         default: return cols[5:4];
      endcase
   endfunction

   // Parity of permutation p of an m by m minor.
   function automatic logic perm_odd(input logic [1:0] m, input logic [2:0] p);
      case (m)
         2'd3: begin
            case (p)
               3'd1, 3'd2, 3'd5: return 1'b1;
               default:          return 1'b0;
            endcase
         end
         2'd2:    return p[0];
         default: return 1'b0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== src/integer_matrix_adjugate_inverse.sv =====
`default_nettype none

// Loads a square signed 8-bit matrix of order n (register matrix_size, 0 acts as 1, above
// 4 acts as 4) one beat per cycle in row-major order, then emits n*n result beats in
// row-major order, one per strobe cycle on rsp_valid; the receiver cannot stall them.
// Each result beat carries the adjugate entry, the determinant and, for a nonsingular
// matrix, the adjugate entry divided by the determinant truncated toward zero; a singular
// matrix comes back unchanged with the singular flag set. After the last element busy
// stays high while one shared 34x8-bit multiplier forms every cofactor as a sum of
// permutation products. Each product is set up, multiplied once per minor row (three
// multiplies at order 4) and then accumulated, and each cofactor sums six products at
// order 4 between an init state and a done state. Each top-row cofactor is then folded
// into the determinant by a multiply state and an add state. Then one restoring divider,
// one quotient bit a cycle, handles each entry: it starts, runs 26 steps and hands over
// the quotient; a singular matrix skips the divider and emits one beat per cycle. Busy
// falls during the last result beat. Writing matrix_size discards a partly loaded
// matrix; write it only while the block is idle.
module integer_matrix_adjugate_inverse
   import imai_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [ELEM_W-1:0] req_matrix_element,
   output logic                         rsp_valid,
   output logic [IDX_W-1:0]             rsp_row_index,
   output logic [IDX_W-1:0]             rsp_col_index,
   output logic signed [ADJ_W-1:0]      rsp_quotient_entry,
   output logic signed [ADJ_W-1:0]      rsp_adjugate_entry,
   output logic signed [DET_W-1:0]      rsp_determinant_value,
   output logic                         rsp_singular,
   output logic                         rsp_last_entry,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [2:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   typedef enum logic [3:0] {
      S_LOAD, S_COF_INIT, S_PROD_INIT, S_MUL, S_ACC, S_COF_DONE,
      S_DET_MUL, S_DET_ADD, S_OUT_START, S_DIV_WAIT
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              size_ff, size_in;
   logic [CNT_W-1:0]        load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0]        ci_ff, ci_in, cj_ff, cj_in;
   logic [2:0]              perm_ff, perm_in;
   logic [1:0]              step_ff, step_in;
   logic signed [DET_W-1:0] prod_ff, prod_in;
   logic signed [ADJ_W-1:0] acc_ff, acc_in;
   logic signed [DET_W-1:0] det_ff, det_in;
   logic [IDX_W-1:0]        oi_ff, oi_in, oj_ff, oj_in;

   logic                    valid_ff, valid_in;
   logic [IDX_W-1:0]        row_ff, row_in, col_ff, col_in;
   logic signed [ADJ_W-1:0] quo_out_ff, quo_out_in, adj_out_ff, adj_out_in;
   logic                    sing_out_ff, sing_out_in, last_ff, last_in;

   // Element and adjugate stores: one write and one read address each.
   logic [ELEM_W-1:0]       loaded_ff [MAX_N*MAX_N];
   logic [ADJ_W-1:0]        adj_ff [MAX_N*MAX_N];
   logic                    load_we, adj_we;
   logic [ADDR_W-1:0]       load_waddr, load_raddr, adj_waddr, adj_raddr;
   logic signed [ADJ_W-1:0] cof;

   logic [2:0]              n;
   logic [1:0]              m;
   logic [CNT_W-1:0]        total, wr_idx;
   logic [2:0]              last_perm;
   logic [1:0]              pc, mr, mc, rd_row, rd_col;
   logic signed [ELEM_W-1:0] entry;
   logic signed [DET_W-1:0] mul_a;
   logic signed [DET_W+ELEM_W-1:0] mul_p;
   logic                    accept, csr_write, singular_now;

   logic                    div_start;
   logic signed [ADJ_W-1:0] div_quo;
   div_status_type          div_stat;

   // Effective order and the sizes that follow from it.
   always_comb begin
      if (size_ff == 3'd0) begin
         n = 3'd1;
      end else if (size_ff > 3'(MAX_N)) begin
         n = 3'(MAX_N);
      end else begin
         n = size_ff;
      end
   end
   assign m     = 2'(n - 3'd1);
   assign total = CNT_W'(n * n);
   always_comb begin
      case (m)
         2'd3:    last_perm = 3'd5;
         2'd2:    last_perm = 3'd1;
         default: last_perm = 3'd0;
      endcase
   end

   // Minor row and column mapped back to the full matrix.
   assign pc = perm_col(m, perm_ff, step_ff);
   assign mr = (step_ff < ci_ff) ? step_ff : 2'(step_ff + 2'd1);
   assign mc = (pc < cj_ff) ? pc : 2'(pc + 2'd1);

   always_comb begin
      case (state_ff)
         S_MUL: begin
            rd_row = mr;
            rd_col = mc;
         end
         S_DET_MUL: begin
            rd_row = '0;
            rd_col = cj_ff;
         end
         default: begin
            rd_row = oi_ff;
            rd_col = oj_ff;
         end
      endcase
   end
   assign load_raddr = ADDR_W'(rd_row * n) + ADDR_W'(rd_col);
   assign entry      = loaded_ff[load_raddr];
   assign adj_raddr  = ADDR_W'(oi_ff * n) + ADDR_W'(oj_ff);

   // The shared multiplier: running product or cofactor times one element.
   assign mul_a = (state_ff == S_DET_MUL) ? DET_W'(acc_ff) : prod_ff;
   assign mul_p = mul_a * entry;

   assign accept       = start && !busy;
   assign csr_write    = psel && penable && pwrite && pready;
   assign wr_idx       = (load_cnt_ff >= total) ? '0 : load_cnt_ff;
   assign load_we      = accept;
   assign load_waddr   = wr_idx[ADDR_W-1:0];
   assign cof          = ((ci_ff[0] ^ cj_ff[0]) != 1'b0) ? ADJ_W'(-acc_ff) : acc_ff;
   assign adj_we       = (state_ff == S_COF_DONE);
   assign adj_waddr    = ADDR_W'(cj_ff * n) + ADDR_W'(ci_ff);
   assign singular_now = (det_ff == '0);
   assign div_start    = (state_ff == S_OUT_START) && !singular_now;

   imai_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start_div (div_start),
      .dividend  (adj_ff[adj_raddr]),
      .divisor   (det_ff),
      .quotient  (div_quo),
      .status    (div_stat)
   );

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      load_cnt_in = load_cnt_ff;
      ci_in       = ci_ff;
      cj_in       = cj_ff;
      perm_in     = perm_ff;
      step_in     = step_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      det_in      = det_ff;
      oi_in       = oi_ff;
      oj_in       = oj_ff;
      valid_in    = 1'b0;
      row_in      = row_ff;
      col_in      = col_ff;
      quo_out_in  = quo_out_ff;
      adj_out_in  = adj_out_ff;
      sing_out_in = sing_out_ff;
      last_in     = last_ff;

      if (csr_write && (paddr[2] == REG_SIZE)) begin
         size_in     = pwdata[2:0];
         load_cnt_in = '0;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (CNT_W'(wr_idx + 1'b1) == total) begin
                  load_cnt_in = '0;
                  ci_in       = '0;
                  cj_in       = '0;
                  det_in      = '0;
                  state_in    = S_COF_INIT;
               end else begin
                  load_cnt_in = CNT_W'(wr_idx + 1'b1);
               end
            end
         end
         S_COF_INIT: begin
            acc_in   = '0;
            perm_in  = '0;
            state_in = S_PROD_INIT;
         end
         S_PROD_INIT: begin
            prod_in  = DET_W'(1);
            step_in  = '0;
            state_in = (m == 2'd0) ? S_ACC : S_MUL;
         end
         S_MUL: begin
            prod_in = mul_p[DET_W-1:0];
            step_in = 2'(step_ff + 2'd1);
            if (step_ff == 2'(m - 2'd1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (perm_odd(m, perm_ff)) begin
               acc_in = ADJ_W'(acc_ff - prod_ff[ADJ_W-1:0]);
            end else begin
               acc_in = ADJ_W'(acc_ff + prod_ff[ADJ_W-1:0]);
            end
            if (perm_ff == last_perm) begin
               state_in = S_COF_DONE;
            end else begin
               perm_in  = 3'(perm_ff + 3'd1);
               state_in = S_PROD_INIT;
            end
         end
         S_COF_DONE: begin
            acc_in = cof;
            if (ci_ff == '0) begin
               state_in = S_DET_MUL;
            end else if (cj_ff == m) begin
               cj_in = '0;
               if (ci_ff == m) begin
                  oi_in    = '0;
                  oj_in    = '0;
                  state_in = S_OUT_START;
               end else begin
                  ci_in    = 2'(ci_ff + 2'd1);
                  state_in = S_COF_INIT;
               end
            end else begin
               cj_in    = 2'(cj_ff + 2'd1);
               state_in = S_COF_INIT;
            end
         end
         S_DET_MUL: begin
            prod_in  = mul_p[DET_W-1:0];
            state_in = S_DET_ADD;
         end
         S_DET_ADD: begin
            det_in = DET_W'(det_ff + prod_ff);
            if (cj_ff == m) begin
               cj_in = '0;
               if (m == 2'd0) begin
                  oi_in    = '0;
                  oj_in    = '0;
                  state_in = S_OUT_START;
               end else begin
                  ci_in    = 2'd1;
                  state_in = S_COF_INIT;
               end
            end else begin
               cj_in    = 2'(cj_ff + 2'd1);
               state_in = S_COF_INIT;
            end
         end
         S_OUT_START, S_DIV_WAIT: begin
            if ((state_ff == S_OUT_START && singular_now) ||
                (state_ff == S_DIV_WAIT && div_stat.done)) begin
               valid_in    = 1'b1;
               row_in      = oi_ff;
               col_in      = oj_ff;
               quo_out_in  = singular_now ? ADJ_W'(entry) : div_quo;
               adj_out_in  = adj_ff[adj_raddr];
               sing_out_in = singular_now;
               last_in     = (oi_ff == m) && (oj_ff == m);
               if (oj_ff == m) begin
                  oj_in = '0;
                  oi_in = 2'(oi_ff + 2'd1);
               end else begin
                  oj_in = 2'(oj_ff + 2'd1);
               end
               state_in = ((oi_ff == m) && (oj_ff == m)) ? S_LOAD : S_OUT_START;
            end else if (state_ff == S_OUT_START) begin
               state_in = S_DIV_WAIT;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         size_ff     <= 3'(MAX_N);
         load_cnt_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         load_cnt_ff <= load_cnt_in;
         valid_ff    <= valid_in;
      end
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      perm_ff     <= perm_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      det_ff      <= det_in;
      oi_ff       <= oi_in;
      oj_ff       <= oj_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      quo_out_ff  <= quo_out_in;
      adj_out_ff  <= adj_out_in;
      sing_out_ff <= sing_out_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         loaded_ff[load_waddr] <= req_matrix_element;
      end
      if (adj_we) begin
         adj_ff[adj_waddr] <= cof;
      end
   end

   assign busy                  = (state_ff != S_LOAD);
   assign rsp_valid             = valid_ff;
   assign rsp_row_index         = row_ff;
   assign rsp_col_index         = col_ff;
   assign rsp_quotient_entry    = quo_out_ff;
   assign rsp_adjugate_entry    = adj_out_ff;
   assign rsp_determinant_value = det_ff;
   assign rsp_singular          = sing_out_ff;
   assign rsp_last_entry        = last_ff;
   assign pready                = 1'b1;
   assign prdata                = (paddr[2] == REG_SIZE) ? {29'd0, size_ff} : 32'd0;

endmodule

`default_nettype wire

// ===== src/imai_divider.sv =====
`default_nettype none

module imai_divider
   import imai_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start_div,
   input  wire logic signed [ADJ_W-1:0]  dividend,
   input  wire logic signed [DET_W-1:0]  divisor,
   output logic signed [ADJ_W-1:0]       quotient,
   output div_status_type                status
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       count_ff, count_in;
   logic [DET_W-1:0] rem_ff, rem_in;
   logic [ADJ_W-1:0] quo_ff, quo_in;
   logic [DET_W-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [DET_W:0]   trial;
   logic             fits;

   // One quotient bit a cycle, restoring division on magnitudes.
   assign trial = {rem_ff, quo_ff[ADJ_W-1]};
   assign fits  = trial >= {1'b0, dmag_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      if (start_div && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend[ADJ_W-1] ? ADJ_W'(-dividend) : ADJ_W'(dividend);
         dmag_in  = divisor[DET_W-1] ? DET_W'(-divisor) : DET_W'(divisor);
         neg_in   = dividend[ADJ_W-1] ^ divisor[DET_W-1];
      end else if (busy_ff) begin
         rem_in   = fits ? DET_W'(trial - {1'b0, dmag_ff}) : trial[DET_W-1:0];
         quo_in   = {quo_ff[ADJ_W-2:0], fits};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign quotient    = neg_ff ? ADJ_W'(-quo_ff) : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef ASSERT_OFF
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_div && !busy_ff |=> busy_ff)
      else $error("divider did not start");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff < 5'(DIV_STEPS))
      else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire
